// ===== sv/esp_pkg.sv =====
// Shared types and constants for the edge subdivision point generator.
// No dependencies.
`default_nettype none
package esp_pkg;
  localparam int MAX_POINTS = 32;
  localparam int NMAX = MAX_POINTS + 2;
  localparam int NW = $clog2(NMAX + 1);
  localparam int QDEPTH = 2;

  localparam logic CFG_SPACING = 1'b0;
  localparam logic CFG_BASE    = 1'b1;

  typedef struct packed {
    logic signed [31:0] ax, ay, az, bx, by_coord, bz;
    logic [NW-1:0] ns;
  } edge_job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_SQ, F_SUM, F_TEST, F_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_NUM, B_DIV, B_EMIT
  } bstate_t;
endpackage
`default_nettype wire

// ===== sv/esp_front.sv =====
// Front end: takes an edge, finds the segment count ns by a search over n.
// Depends on esp_pkg.
`default_nettype none
module esp_front import esp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [30:0] spacing,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [191:0] in_data,
  output logic      job_valid,
  input  wire logic job_ready,
  output edge_job_t job
);
  fstate_t state, state_next;
  edge_job_t cur;
  logic [1:0] axis;
  logic [63:0] sq;
  logic [65:0] slen;
  logic [NW-1:0] n;
  logic [36:0] t;
  logic [73:0] t2;
  logic signed [32:0] d;
  logic [31:0] m;

  always_comb begin
    unique case (axis)
      2'd0: d = 33'(cur.ax) - 33'(cur.bx);
      2'd1: d = 33'(cur.ay) - 33'(cur.by_coord);
      default: d = 33'(cur.az) - 33'(cur.bz);
    endcase
    m = d[32] ? 32'(-d) : d[31:0];
    t2 = t * t;
  end

  assign in_ready = (state == F_IDLE);
  assign job_valid = (state == F_PUSH);
  assign job = cur;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_valid) state_next = F_SQ;
      F_SQ: state_next = F_SUM;
      F_SUM: state_next = (axis == 2'd2) ? F_TEST : F_SQ;
      F_TEST: begin
        if (74'(slen) < t2 || n == NW'(NMAX)) begin
          state_next = (74'(slen) >= t2 || n > NW'(2)) ? F_PUSH : F_IDLE;
        end
      end
      F_PUSH: if (job_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
    unique case (state)
      F_IDLE: begin
        cur.ax <= in_data[31:0];
        cur.ay <= in_data[63:32];
        cur.az <= in_data[95:64];
        cur.bx <= in_data[127:96];
        cur.by_coord <= in_data[159:128];
        cur.bz <= in_data[191:160];
        cur.ns <= NW'(0);
        axis <= 2'd0;
        slen <= '0;
        n <= NW'(1);
        t <= 37'(spacing);
      end
      F_SQ: sq <= m * m;
      F_SUM: begin
        slen <= slen + 66'(sq);
        axis <= axis + 2'd1;
      end
      F_TEST: begin
        if (74'(slen) >= t2) begin
          cur.ns <= n;
          n <= n + NW'(1);
          t <= t + 37'(spacing);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/esp_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on esp_pkg.
`default_nettype none
module esp_queue import esp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  edge_job_t wr_job,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output edge_job_t rd_job
);
  edge_job_t mem [QDEPTH];
  logic wp, rp;
  logic [1:0] cnt;
  logic wr, rd;
  assign wr_ready = (cnt != 2'(QDEPTH));
  assign rd_valid = (cnt != 2'd0);
  assign rd_job = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
    if (wr) mem[wp] <= wr_job;
  end
endmodule
`default_nettype wire

// ===== sv/esp_divider.sv =====
// Serial signed floor divider: 40-bit numerator by small positive divisor.
// Depends on esp_pkg.
`default_nettype none
module esp_divider import esp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic signed [39:0] num,
  input  wire logic [NW-1:0] den,
  output logic      done,
  output logic [31:0] quo
);
  logic busy, neg;
  logic [5:0] cnt;
  logic [39:0] q;
  logic [NW:0] r;
  logic [NW:0] rs;
  logic [39:0] qf;
  assign rs = {r[NW-1:0], q[39]};
  assign qf = neg ? ((r != '0) ? ~q : -q) : q;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 6'd40; neg <= num[39];
        q <= num[39] ? 40'(-num) : num; r <= '0;
      end else if (busy) begin
        if (cnt == 6'd0) begin
          busy <= 1'b0; done <= 1'b1; quo <= qf[31:0];
        end else begin
          cnt <= cnt - 6'd1;
          if (rs >= {1'b0, den}) begin
            r <= rs - {1'b0, den}; q <= {q[38:0], 1'b1};
          end else begin
            r <= rs; q <= {q[38:0], 1'b0};
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/esp_back.sv =====
// Back end: emits the interior points of a job, one coordinate division at a time.
// Depends on esp_pkg and esp_divider.
`default_nettype none
module esp_back import esp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [19:0] base_vertex_index,
  input  wire logic job_valid,
  output logic      job_ready,
  input  edge_job_t job,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [127:0] out_data,
  output logic      out_user,
  output logic      out_last
);
  bstate_t state, state_next;
  edge_job_t cur;
  logic [NW-1:0] j;
  logic [1:0] axis;
  logic [19:0] vcount;
  logic [31:0] p [3];
  logic signed [39:0] prod;
  logic signed [31:0] ca, cb;
  logic [NW-1:0] nsm;
  logic dstart, ddone, err;
  logic [31:0] quo;

  assign nsm = cur.ns - j;
  assign err = (cur.ns - NW'(1)) > NW'(MAX_POINTS);
  always_comb begin
    unique case (axis)
      2'd0: begin ca = cur.ax; cb = cur.bx; end
      2'd1: begin ca = cur.ay; cb = cur.by_coord; end
      default: begin ca = cur.az; cb = cur.bz; end
    endcase
    prod = 40'(ca) * 40'($signed({1'b0, nsm})) + 40'(cb) * 40'($signed({1'b0, j}));
  end

  esp_divider u_div (.clk, .rst, .start(dstart), .num(prod), .den(cur.ns), .done(ddone), .quo);

  assign job_ready = (state == B_IDLE);
  assign out_valid = (state == B_EMIT);
  assign dstart = (state == B_NUM);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = (job.ns - NW'(1) > NW'(MAX_POINTS)) ? B_EMIT : B_NUM;
      B_NUM: state_next = B_DIV;
      B_DIV: if (ddone) state_next = (axis == 2'd2) ? B_EMIT : B_NUM;
      B_EMIT: if (out_ready) state_next = (err || j == cur.ns - NW'(1)) ? B_IDLE : B_NUM;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE; vcount <= '0;
    end else begin
      state <= state_next;
      if (state == B_EMIT && out_ready && !err) vcount <= vcount + 20'd1;
    end
    unique case (state)
      B_IDLE: begin
        cur <= job; j <= NW'(1); axis <= 2'd0;
        p[0] <= '0; p[1] <= '0; p[2] <= '0;
      end
      B_DIV: if (ddone) begin
        p[axis] <= quo;
        if (axis != 2'd2) axis <= axis + 2'd1;
      end
      B_EMIT: if (out_ready) begin
        j <= j + NW'(1); axis <= 2'd0;
      end
      default: ;
    endcase
  end

  assign out_data = {6'd0, base_vertex_index + vcount,
                     err ? 6'd0 : 6'(j), p[2], p[1], p[0]};
  assign out_user = err;
  assign out_last = err || (j == cur.ns - NW'(1));
endmodule
`default_nettype wire

// ===== sv/edge_subdivision_point_generator_core.sv =====
// Edge subdivision point generator, top level.
// Depends on esp_pkg, esp_front, esp_queue, esp_back.
//
// Input stream s_axis: one edge per request, tdata = ax,ay,az,bx,by_coord,bz
// (32 bits each, lowest first). Output stream m_axis: one request per interior
// point; tdata = px,py,pz,point_number,vertex_index; tuser = too_many;
// tlast marks the final result of the edge. Edges with ns <= 1 give nothing.
// The front finds ns by testing n = 1..34 against the squared length, one n
// per cycle after squaring and summing the three coordinate differences. The
// back runs one serial 40-step divide per coordinate, three per point. A
// two-entry queue lets the front search the next edge while the back emits.
// Reset (rst, synchronous) empties the queue, sets spacing 65536, base 0 and
// clears the vertex count. A stalled m_axis_tready holds the current point;
// the front keeps working until the queue fills. Configuration is written
// via cfg_we/cfg_index/cfg_data.
`default_nettype none
module edge_subdivision_point_generator_core import esp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_index,
  input  wire logic [30:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  input  wire logic [191:0] s_axis_tdata, // ax, ay, az, bx, by_coord, bz
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [127:0] m_axis_tdata,      // px, py, pz, point_number, vertex_index
  output logic      m_axis_tuser,         // too_many
  output logic      m_axis_tlast
);
  logic [30:0] spacing;
  logic [19:0] base_vertex_index;
  logic fv, fr, bv, br;
  edge_job_t fj, bj;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= 31'd65536; base_vertex_index <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPACING: spacing <= cfg_data;
        CFG_BASE: base_vertex_index <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  esp_front u_front (.clk, .rst, .spacing, .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready), .in_data(s_axis_tdata),
    .job_valid(fv), .job_ready(fr), .job(fj));
  esp_queue u_queue (.clk, .rst, .wr_valid(fv), .wr_ready(fr), .wr_job(fj),
    .rd_valid(bv), .rd_ready(br), .rd_job(bj));
  esp_back u_back (.clk, .rst, .base_vertex_index, .job_valid(bv), .job_ready(br),
    .job(bj), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser), .out_last(m_axis_tlast));
endmodule
`default_nettype wire
